[design/dopf_pkg.sv]
`default_nettype none

package dopf_pkg;

    // Buffer geometry
    localparam int DEPTH         = 512;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int OCC_W         = $clog2(DEPTH + 1);

    // Fixed port widths
    localparam int MODE_W     = 2;
    localparam int PORT_PAY_W = 64;
    localparam int FILL_W     = 10;
    localparam int TOTAL_W    = 32;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLR = 2'd2;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [OCC_W-1:0]         t_occ;
    typedef logic [TOTAL_W-1:0]       t_total;
    typedef logic [PAYLOAD_WIDTH-1:0] t_data;

    // Result of one transaction, minus the payload read from the store
    typedef struct packed {
        logic              ok;
        logic              deq_hit;
        logic              dropped;
        logic [FILL_W-1:0] fill;
        t_total            enq_total;
        t_total            deq_total;
        t_total            drop_total;
    } t_result;

    // Circular pointer advance, wraps at DEPTH
    function automatic t_addr ptr_next(input t_addr p);
        t_addr q;
        if (p == t_addr'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + t_addr'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

[design/dopf_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module dopf_ram #(
    parameter int DEPTH_P = 2,
    parameter int WIDTH_P = 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH_P)-1:0] i_waddr,
    input  wire logic [WIDTH_P-1:0]         i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH_P)-1:0] i_raddr,
    output logic      [WIDTH_P-1:0]         o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/drop_oldest_packet_fifo_top.sv]
`default_nettype none

// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  i_mode, i_payload_in
// out      output     o_valid / i_stall  o_ok, o_payload_out, o_dropped_now,
//                                        o_fill_count, o_total_enqueued,
//                                        o_total_dequeued, o_total_dropped
//
// One transaction per cycle sustained while the output is not stalled;
// a result moves from stage one, which covers the registered read of the
// packet store, to the output register. Pointers, fill count and totals
// update at acceptance, so back-to-back operations need no interlock.
// Reset (synchronous, active low) empties the buffer and clears the totals.
// A stalled output holds; one more transaction is buffered behind it.
module drop_oldest_packet_fifo_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [dopf_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [dopf_pkg::PORT_PAY_W-1:0] i_payload_in,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_ok,
    output logic      [dopf_pkg::PORT_PAY_W-1:0] o_payload_out,
    output logic                                 o_dropped_now,
    output logic      [dopf_pkg::FILL_W-1:0]     o_fill_count,
    output logic      [dopf_pkg::TOTAL_W-1:0]    o_total_enqueued,
    output logic      [dopf_pkg::TOTAL_W-1:0]    o_total_dequeued,
    output logic      [dopf_pkg::TOTAL_W-1:0]    o_total_dropped
);

    // Buffer state
    dopf_pkg::t_addr  r_wptr, n_wptr;
    dopf_pkg::t_addr  r_rptr, n_rptr;
    dopf_pkg::t_occ   r_occ, n_occ;
    dopf_pkg::t_total r_enq, n_enq;
    dopf_pkg::t_total r_deq, n_deq;
    dopf_pkg::t_total r_drop, n_drop;

    // Pipeline
    logic              r_s1_valid;
    dopf_pkg::t_result r_s1_res, n_res;
    logic              r_out_valid;
    dopf_pkg::t_result r_out_res;
    dopf_pkg::t_data   r_out_payload;

    logic            w_in_acc;
    logic            w_out_free;
    logic            w_s1_move;
    logic            w_we;
    logic            w_re;
    dopf_pkg::t_data w_rdata;

    // Handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_stall    = r_s1_valid && !w_out_free;
    assign w_in_acc   = i_valid && !o_stall;

    // Operation decode and next state
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_occ  = r_occ;
        n_enq  = r_enq;
        n_deq  = r_deq;
        n_drop = r_drop;
        w_we   = 1'b0;
        w_re   = 1'b0;
        n_res  = '0;
        unique case (i_mode)
            dopf_pkg::MODE_ENQ: begin
                if (r_occ == dopf_pkg::t_occ'(dopf_pkg::DEPTH)) begin
                    // full: drop the oldest, count stays
                    n_rptr        = dopf_pkg::ptr_next(r_rptr);
                    n_drop        = r_drop + 1'b1;
                    n_res.dropped = 1'b1;
                end else begin
                    n_occ = r_occ + 1'b1;
                end
                n_wptr   = dopf_pkg::ptr_next(r_wptr);
                n_enq    = r_enq + 1'b1;
                w_we     = w_in_acc;
                n_res.ok = 1'b1;
            end
            dopf_pkg::MODE_DEQ: begin
                if (r_occ != '0) begin
                    n_rptr        = dopf_pkg::ptr_next(r_rptr);
                    n_occ         = r_occ - 1'b1;
                    n_deq         = r_deq + 1'b1;
                    w_re          = w_in_acc;
                    n_res.ok      = 1'b1;
                    n_res.deq_hit = 1'b1;
                end
            end
            dopf_pkg::MODE_CLR: begin
                n_wptr   = '0;
                n_rptr   = '0;
                n_occ    = '0;
                n_res.ok = 1'b1;
            end
            default: begin
                // unused code: no operation
            end
        endcase
        n_res.fill       = dopf_pkg::FILL_W'(n_occ);
        n_res.enq_total  = n_enq;
        n_res.deq_total  = n_deq;
        n_res.drop_total = n_drop;
    end

    // Packet store; read data is held while the result waits in stage one
    dopf_ram #(
        .DEPTH_P (dopf_pkg::DEPTH),
        .WIDTH_P (dopf_pkg::PAYLOAD_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (i_payload_in[dopf_pkg::PAYLOAD_WIDTH-1:0]),
        .i_re    (w_re),
        .i_raddr (r_rptr),
        .o_rdata (w_rdata)
    );

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_occ  <= '0;
            r_enq  <= '0;
            r_deq  <= '0;
            r_drop <= '0;
        end else if (w_in_acc) begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_occ  <= n_occ;
            r_enq  <= n_enq;
            r_deq  <= n_deq;
            r_drop <= n_drop;
        end
    end

    // Stage one: result fields while the store read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_res <= n_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_res     <= r_s1_res;
            r_out_payload <= r_s1_res.deq_hit ? w_rdata : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_res.ok;
    assign o_payload_out    = dopf_pkg::PORT_PAY_W'(r_out_payload);
    assign o_dropped_now    = r_out_res.dropped;
    assign o_fill_count     = r_out_res.fill;
    assign o_total_enqueued = r_out_res.enq_total;
    assign o_total_dequeued = r_out_res.deq_total;
    assign o_total_dropped  = r_out_res.drop_total;

`ifndef SYNTHESIS
    // Fill count never exceeds the buffer depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= dopf_pkg::t_occ'(dopf_pkg::DEPTH))
        else $error("occupancy above depth");

    // Input is only held off while stage one is occupied
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("input stalled with empty stage one");

    // A drop is only reported on a successful enqueue into a full buffer
    a_drop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped_now) |->
            (o_ok && o_fill_count == dopf_pkg::FILL_W'(dopf_pkg::DEPTH)))
        else $error("drop reported without full enqueue");

    // Failed operations return zero payload
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_payload_out == '0))
        else $error("nonzero payload on failure");
`endif

endmodule

`default_nettype wire
